// ===== src/bmhq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared constants of the binary min-heap queue: default sizes and op codes.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned DEF_KEY_BITS = 32;

  localparam int unsigned FUNC_BITS  = 2;
  localparam int unsigned VALUE_BITS = 32;

  localparam logic [FUNC_BITS-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_BUILD  = 2'd2;

endpackage
`default_nettype wire

// ===== src/binary_min_heap_queue_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_min_heap_queue_top
// Binary min-heap of signed keys held in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries func_i and value_i.
//   func insert appends a key and sifts it up, append stores it unordered,
//   build turns the stored entries into a heap; other codes only report.
//   Output channel (out_valid_o / out_stall_i) gives one beat per input beat:
//   the root key, the entry count, a rejected flag (insert/append on a full
//   heap) and an empty flag.
//   One operation is in flight at a time; the accesses to the key memory
//   (one synchronous read port and one write port) set the duration.
//   Append, reject and no-op go straight to the response; insert reads
//   and compares one parent per level climbed and writes the key where it
//   stops; build sinks each key from the last parent down to the root,
//   reading the node and then its children for each level. The result is
//   loaded into the output register after the last memory step.
//   The result sits in an output register; the next beat is taken while it
//   still waits, and a stalled receiver only holds back the following result.
//   Reset empties the heap (count zero) and drops any pending result; the
//   memory contents are not cleared.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_top #(
  parameter int unsigned CAPACITY = bmhq_pkg::DEF_CAPACITY,
  parameter int unsigned KEY_BITS = bmhq_pkg::DEF_KEY_BITS,
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_stall_o,
  input  wire        [bmhq_pkg::FUNC_BITS-1:0]   func_i,
  input  wire signed [bmhq_pkg::VALUE_BITS-1:0]  value_i,
  output logic                                   out_valid_o,
  input  wire                                    out_stall_i,
  output logic signed [bmhq_pkg::VALUE_BITS-1:0] min_value_o,
  output logic       [CW-1:0]                    entry_count_o,
  output logic                                   rejected_o,
  output logic                                   is_empty_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UP_RD  = 4'd1;
  localparam logic [3:0] S_UP_CMP = 4'd2;
  localparam logic [3:0] S_UP_FIN = 4'd3;
  localparam logic [3:0] S_DN_LD  = 4'd4;
  localparam logic [3:0] S_DN_V   = 4'd5;
  localparam logic [3:0] S_DN_CHK = 4'd6;
  localparam logic [3:0] S_DN_R   = 4'd7;
  localparam logic [3:0] S_DN_CMP = 4'd8;
  localparam logic [3:0] S_DN_END = 4'd9;
  localparam logic [3:0] S_RESP   = 4'd10;

  localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_W = CW'(1);

  // key memory, node i lives at address i-1
  logic signed [KEY_BITS-1:0] mem [CAPACITY];
  logic signed [KEY_BITS-1:0] rd_data_q;
  logic signed [KEY_BITS-1:0] root_q;

  logic                       mem_we;
  logic [CW-1:0]              mem_wnode;
  logic signed [KEY_BITS-1:0] mem_wdata;
  logic [CW-1:0]              rd_node;

  logic [3:0]                 state_q, state_d;
  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              node_q, node_d;
  logic [CW-1:0]              bnode_q, bnode_d;
  logic signed [KEY_BITS-1:0] val_q, val_d;
  logic signed [KEY_BITS-1:0] left_q, left_d;
  logic                       rej_q, rej_d;

  logic                       out_valid_q;
  logic signed [bmhq_pkg::VALUE_BITS-1:0] min_q;
  logic [CW-1:0]              cnt_q;
  logic                       orej_q;
  logic                       emp_q;
  logic                       out_load;

  logic signed [KEY_BITS-1:0] key_in;
  logic [CW:0]                left_idx;
  logic [CW:0]                right_idx;
  logic                       left_ok;
  logic                       right_ok;
  logic                       l_lt;
  logic                       r_lt;
  logic signed [KEY_BITS-1:0] cand;

  assign key_in    = KEY_BITS'(value_i);
  assign left_idx  = {node_q, 1'b0};
  assign right_idx = {node_q, 1'b1};
  assign left_ok   = left_idx <= {1'b0, count_q};
  assign right_ok  = right_idx <= {1'b0, count_q};
  assign l_lt      = left_q < val_q;
  assign cand      = l_lt ? left_q : val_q;
  assign r_lt      = right_ok && (rd_data_q < cand);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AW'(mem_wnode - ONE_W)] <= mem_wdata;
    end
    rd_data_q <= mem[AW'(rd_node - ONE_W)];
  end

  // copy of node 1 so the root is ready at response time
  always_ff @(posedge clk_i) begin
    if (mem_we && (mem_wnode == ONE_W)) begin
      root_q <= mem_wdata;
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    node_d    = node_q;
    bnode_d   = bnode_q;
    val_d     = val_q;
    left_d    = left_q;
    rej_d     = rej_q;
    mem_we    = 1'b0;
    mem_wnode = node_q;
    mem_wdata = val_q;
    rd_node   = node_q;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rej_d   = 1'b0;
          state_d = S_RESP;
          case (func_i)
            bmhq_pkg::FUNC_INSERT, bmhq_pkg::FUNC_APPEND: begin
              if (count_q >= CAP_W) begin
                rej_d = 1'b1;
              end else begin
                count_d = count_q + ONE_W;
                node_d  = count_q + ONE_W;
                val_d   = key_in;
                if ((func_i == bmhq_pkg::FUNC_APPEND) || (count_q == '0)) begin
                  mem_we    = 1'b1;
                  mem_wnode = count_q + ONE_W;
                  mem_wdata = key_in;
                end else begin
                  state_d = S_UP_RD;
                end
              end
            end
            bmhq_pkg::FUNC_BUILD: begin
              if (count_q > ONE_W) begin
                bnode_d = count_q >> 1;
                node_d  = count_q >> 1;
                state_d = S_DN_LD;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_UP_RD: begin
        rd_node = node_q >> 1;
        state_d = S_UP_CMP;
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (rd_data_q > val_q) begin
          // parent moves down into the hole
          mem_wdata = rd_data_q;
          node_d    = node_q >> 1;
          state_d   = ((node_q >> 1) == ONE_W) ? S_UP_FIN : S_UP_RD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_UP_FIN: begin
        mem_we  = 1'b1;
        state_d = S_RESP;
      end
      S_DN_LD: begin
        state_d = S_DN_V;
      end
      S_DN_V: begin
        val_d   = rd_data_q;
        state_d = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (left_ok) begin
          rd_node = left_idx[CW-1:0];
          state_d = S_DN_R;
        end else begin
          state_d = S_DN_END;
        end
      end
      S_DN_R: begin
        left_d = rd_data_q;
        if (right_ok) begin
          rd_node = right_idx[CW-1:0];
        end
        state_d = S_DN_CMP;
      end
      S_DN_CMP, S_DN_END: begin
        mem_we = 1'b1;
        if ((state_q == S_DN_CMP) && r_lt) begin
          mem_wdata = rd_data_q;
          node_d    = right_idx[CW-1:0];
          state_d   = S_DN_CHK;
        end else if ((state_q == S_DN_CMP) && l_lt) begin
          mem_wdata = left_q;
          node_d    = left_idx[CW-1:0];
          state_d   = S_DN_CHK;
        end else if (bnode_q > ONE_W) begin
          // key settled, move on to the previous build node
          bnode_d = bnode_q - ONE_W;
          node_d  = bnode_q - ONE_W;
          state_d = S_DN_LD;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    bnode_q <= bnode_d;
    val_q   <= val_d;
    left_q  <= left_d;
    rej_q   <= rej_d;
    if (out_load) begin
      min_q  <= (count_q == '0) ? '0 : bmhq_pkg::VALUE_BITS'(root_q);
      cnt_q  <= count_q;
      orej_q <= rej_q;
      emp_q  <= (count_q == '0);
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign min_value_o   = min_q;
  assign entry_count_o = cnt_q;
  assign rejected_o    = orej_q;
  assign is_empty_o    = emp_q;

endmodule
`default_nettype wire

// ===== src/bmhq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks of the heap queue result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bmhq_checker #(
  parameter int unsigned CAPACITY = bmhq_pkg::DEF_CAPACITY,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input wire                                   clk_i,
  input wire                                   rst_ni,
  input wire                                   out_valid_o,
  input wire                                   out_stall_i,
  input wire signed [bmhq_pkg::VALUE_BITS-1:0] min_value_o,
  input wire        [CW-1:0]                   entry_count_o,
  input wire                                   rejected_o,
  input wire                                   is_empty_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(min_value_o)
      && $stable(entry_count_o) && $stable(rejected_o))
    else $error("result beat changed while stalled");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with count");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> (min_value_o == '0))
    else $error("empty heap reports nonzero root");

  a_reject_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rejected_o |-> (entry_count_o == CW'(CAPACITY)))
    else $error("reject without a full heap");

endmodule

bind binary_min_heap_queue_top bmhq_checker #(.CAPACITY(CAPACITY)) u_bmhq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .min_value_o   (min_value_o),
  .entry_count_o (entry_count_o),
  .rejected_o    (rejected_o),
  .is_empty_o    (is_empty_o)
);
`default_nettype wire

// ===== tb/tb_binary_min_heap_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_min_heap_queue_top
// Self-checking bench for the binary min-heap queue. A driver feeds insert,
// append, build and unused-code beats from a queue, and a monitor checks
// every result beat against a heap predictor kept in the bench. Both sides
// idle at random, and the receiver holds off once long enough to back up
// the block.
// ----------------------------------------------------------------------------
module tb_binary_min_heap_queue_top;

  localparam int unsigned CAP = bmhq_pkg::DEF_CAPACITY;
  localparam int unsigned CNT_W = $clog2(CAP + 1);
  localparam int unsigned FB = bmhq_pkg::FUNC_BITS;
  localparam int unsigned VB = bmhq_pkg::VALUE_BITS;
  localparam logic [FB-1:0] FUNC_NOP = 2'd3;
  localparam int LONG_HOLD = 300;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [FB-1:0]        func;
    logic signed [VB-1:0] value;
  } heap_op_t;

  typedef struct packed {
    logic signed [VB-1:0] min_value;
    logic [CNT_W-1:0]     count;
    logic                 rejected;
    logic                 empty;
  } heap_status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic [FB-1:0] func = bmhq_pkg::FUNC_INSERT;
  logic signed [VB-1:0] value = '0;
  logic out_stall = 1'b0;
  wire in_stall;
  wire out_valid;
  wire signed [VB-1:0] min_value;
  wire [CNT_W-1:0] entry_count;
  wire rejected;
  wire is_empty;

  binary_min_heap_queue_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (func),
    .value_i      (value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .min_value_o  (min_value),
    .entry_count_o(entry_count),
    .rejected_o   (rejected),
    .is_empty_o   (is_empty)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  heap_op_t op_q[$];
  heap_status_t status_q[$];
  int errors = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int holds_asked = 0;

  // bench copy of the heap
  logic signed [VB-1:0] heap_keys[1:CAP];
  int unsigned heap_fill = 0;

  function automatic heap_status_t apply_heap_op(heap_op_t op);
    heap_status_t st;
    int unsigned node, best, kid;
    logic signed [VB-1:0] tmp;
    bit sinking;
    st.rejected = 1'b0;
    case (op.func)
      bmhq_pkg::FUNC_INSERT, bmhq_pkg::FUNC_APPEND: begin
        if (heap_fill >= CAP) begin
          st.rejected = 1'b1;
        end else begin
          heap_fill++;
          heap_keys[heap_fill] = op.value;
          node = heap_fill;
          // climb only past strictly larger parents
          while (op.func == bmhq_pkg::FUNC_INSERT && node > 1 &&
                 heap_keys[node / 2] > heap_keys[node]) begin
            tmp = heap_keys[node / 2];
            heap_keys[node / 2] = heap_keys[node];
            heap_keys[node] = tmp;
            node = node / 2;
          end
        end
      end
      bmhq_pkg::FUNC_BUILD: begin
        for (int i = int'(heap_fill / 2); i >= 1; i--) begin
          node = i;
          sinking = 1'b1;
          while (sinking) begin
            best = node;
            kid = 2 * node;
            // left child wins a tie
            if (kid <= heap_fill && heap_keys[kid] < heap_keys[best]) best = kid;
            if (kid + 1 <= heap_fill && heap_keys[kid + 1] < heap_keys[best]) best = kid + 1;
            if (best == node) begin
              sinking = 1'b0;
            end else begin
              tmp = heap_keys[best];
              heap_keys[best] = heap_keys[node];
              heap_keys[node] = tmp;
              node = best;
            end
          end
        end
      end
      default: ;
    endcase
    st.min_value = (heap_fill != 0) ? heap_keys[1] : '0;
    st.count = CNT_W'(heap_fill);
    st.empty = (heap_fill == 0);
    return st;
  endfunction

  function automatic int idle_len(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [VB-1:0] random_key();
    int r;
    r = $urandom_range(0, 15);
    // narrow range now and then so equal keys show up
    if (r < 4) return $urandom_range(0, 8) - 4;
    if (r == 4) return {1'b1, {(VB - 1){1'b0}}};
    if (r == 5) return {1'b0, {(VB - 1){1'b1}}};
    return $urandom;
  endfunction

  function automatic heap_op_t random_heap_op();
    heap_op_t op;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) op.func = bmhq_pkg::FUNC_INSERT;
    else if (r < 78) op.func = bmhq_pkg::FUNC_APPEND;
    else if (r < 92) op.func = bmhq_pkg::FUNC_BUILD;
    else op.func = FUNC_NOP;
    op.value = random_key();
    return op;
  endfunction

  task automatic add_op(logic [FB-1:0] f, logic signed [VB-1:0] v);
    op_q.push_back('{func: f, value: v});
  endtask

  // sampled away from the rising edge so that driver updates have settled
  task automatic wait_drained();
    while (op_q.size() != 0 || in_valid || status_q.size() != 0) @(negedge clk_i);
  endtask

  // driver
  heap_op_t on_bus;
  int tx_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      func <= bmhq_pkg::FUNC_INSERT;
      value <= '0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) status_q.push_back(apply_heap_op(on_bus));
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (op_q.size() != 0) begin
          on_bus = op_q.pop_front();
          in_valid <= 1'b1;
          func <= on_bus.func;
          value <= on_bus.value;
          tx_gap = idle_len(tx_idle_on);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  int stall_left = 0;
  int holds_done = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    heap_status_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          $display("%0t: result beat expected none actual min %0d count %0d", $realtime,
                   min_value, entry_count);
          errors++;
        end else begin
          want = status_q.pop_front();
          if (min_value !== want.min_value) begin
            $display("%0t: min_value expected %0d actual %0d", $realtime, want.min_value,
                     min_value);
            errors++;
          end
          if (entry_count !== want.count) begin
            $display("%0t: entry_count expected %0d actual %0d", $realtime, want.count,
                     entry_count);
            errors++;
          end
          if (rejected !== want.rejected) begin
            $display("%0t: rejected expected %0b actual %0b", $realtime, want.rejected,
                     rejected);
            errors++;
          end
          if (is_empty !== want.empty) begin
            $display("%0t: is_empty expected %0b actual %0b", $realtime, want.empty, is_empty);
            errors++;
          end
        end
      end
      if (holds_done != holds_asked) begin
        holds_done++;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = idle_len(rx_idle_on);
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  // watchdog: no beat on either side for too long while work is outstanding
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else if (op_q.size() != 0 || in_valid || status_q.size() != 0) begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    // empty heap, extremes, ties, out-of-order appends then builds
    add_op(FUNC_NOP, 32'h5555_5555);
    add_op(bmhq_pkg::FUNC_BUILD, 32'hAAAA_AAAA);
    add_op(bmhq_pkg::FUNC_INSERT, 32'h7FFF_FFFF);
    add_op(bmhq_pkg::FUNC_INSERT, 32'h8000_0000);
    add_op(bmhq_pkg::FUNC_INSERT, -1);
    add_op(bmhq_pkg::FUNC_INSERT, -1);
    add_op(bmhq_pkg::FUNC_INSERT, 0);
    add_op(bmhq_pkg::FUNC_APPEND, 32'h7FFF_FFFF);
    add_op(bmhq_pkg::FUNC_APPEND, -2);
    add_op(bmhq_pkg::FUNC_APPEND, 32'h8000_0000);
    add_op(FUNC_NOP, 32'hFFFF_FFFF);
    add_op(bmhq_pkg::FUNC_BUILD, 0);
    add_op(bmhq_pkg::FUNC_INSERT, 5);
    add_op(bmhq_pkg::FUNC_INSERT, 5);
    add_op(bmhq_pkg::FUNC_APPEND, 3);
    add_op(bmhq_pkg::FUNC_APPEND, 3);
    add_op(bmhq_pkg::FUNC_APPEND, 1);
    add_op(bmhq_pkg::FUNC_BUILD, 32'h0000_FFFF);
    add_op(bmhq_pkg::FUNC_APPEND, 32'hFFFF_0000);
    add_op(bmhq_pkg::FUNC_INSERT, 32'h8000_0001);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // wait for every result before going on
    wait_drained();

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (40) op_q.push_back(random_heap_op());
    holds_asked++;
    wait_drained();

    for (int chunk = 0; chunk < 7; chunk++) begin
      tx_idle_on = (chunk % 3 != 0);
      rx_idle_on = (chunk % 3 != 1);
      repeat (190) op_q.push_back(random_heap_op());
      while (op_q.size() > 20) @(posedge clk_i);
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
